// ----- rtl/core/adc_resistance_ascii_reporter_unit_defines.svh -----
// assertion macros shared by the reporter rtl
`ifndef ADC_RESISTANCE_ASCII_REPORTER_UNIT_DEFINES_SVH
`define ADC_RESISTANCE_ASCII_REPORTER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ADC_RAR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ADC_RAR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/adc_rar_pkg.sv -----
// types, constants and lookup functions shared by the reporter modules
package adc_rar_pkg;

	localparam int SAMPLE_W = 12;
	localparam int REQ_W    = 7;
	localparam int VOLT_W   = 6;
	localparam int BCD_W    = 20;
	localparam int NDIG_W   = 3;
	localparam int IDX_W    = 4;

	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [REQ_W-1:0] REQ_MEASURE = 7'h31;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [IDX_W-1:0] MSG_LEN = 4'd11;
	localparam logic [VOLT_W-1:0] VOLT_SAT = 6'd31;

	typedef struct packed {
		logic                report;
		logic                err;
		logic [BCD_W-1:0]    bcd;
		logic [NDIG_W-1:0]   ndig;
	} job_t;

	// resistance for each tenth-of-volt step, in packed bcd
	function automatic logic [BCD_W-1:0] volt_to_bcd(input logic [VOLT_W-1:0] v);
		logic [BCD_W-1:0] r;
		case (v)
			6'd1:  r = 20'h00062;
			6'd2:  r = 20'h00129;
			6'd3:  r = 20'h00200;
			6'd4:  r = 20'h00277;
			6'd5:  r = 20'h00357;
			6'd6:  r = 20'h00444;
			6'd7:  r = 20'h00540;
			6'd8:  r = 20'h00645;
			6'd9:  r = 20'h00769;
			6'd10: r = 20'h00869;
			6'd11: r = 20'h01000;
			6'd12: r = 20'h01176;
			6'd13: r = 20'h01333;
			6'd14: r = 20'h01538;
			6'd15: r = 20'h01666;
			6'd16: r = 20'h02000;
			6'd17: r = 20'h02222;
			6'd18: r = 20'h02500;
			6'd19: r = 20'h02857;
			6'd20: r = 20'h03333;
			6'd21: r = 20'h04000;
			6'd22: r = 20'h04000;
			6'd23: r = 20'h05000;
			6'd24: r = 20'h06666;
			6'd25: r = 20'h06666;
			6'd26: r = 20'h10000;
			6'd27: r = 20'h10000;
			6'd28: r = 20'h20000;
			6'd29: r = 20'h20000;
			6'd30: r = 20'h20000;
			default: r = '0;
		endcase
		return r;
	endfunction

	// "No action" CR LF
	function automatic logic [7:0] msg_char(input logic [IDX_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:  c = 8'h4E;
			4'd1:  c = 8'h6F;
			4'd2:  c = 8'h20;
			4'd3:  c = 8'h61;
			4'd4:  c = 8'h63;
			4'd5:  c = 8'h74;
			4'd6:  c = 8'h69;
			4'd7:  c = 8'h6F;
			4'd8:  c = 8'h6E;
			4'd9:  c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/adc_rar_front.sv -----
// front end: takes items, keeps request and offset, turns a poll into a report or no-action job
module adc_rar_front import adc_rar_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SAMPLE_W-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [7:0]          rx_byte,
	input  logic                adc_ready,
	input  logic [SAMPLE_W-1:0] adc_sample,
	input  logic                q_full,
	output logic                q_push,
	output job_t                q_wdata
);

	logic [REQ_W-1:0]    request_char_q;
	logic [SAMPLE_W-1:0] cal_offset_q;
	logic                accept;
	logic [SAMPLE_W-1:0] diff;
	logic [17:0]         scaled;
	logic [VOLT_W-1:0]   volt;
	logic [BCD_W-1:0]    bcd;
	logic                measure;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_char_q <= '0;
			cal_offset_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				cal_offset_q <= cfg_data;
			if (accept && !cmd)
				request_char_q <= rx_byte[REQ_W-1:0];
		end
	end

	// v = d*330/40960 = d*33/4096
	assign diff    = (adc_sample > cal_offset_q) ? adc_sample - cal_offset_q : '0;
	assign scaled  = {1'b0, diff, 5'b0} + {6'b0, diff};
	assign volt    = scaled[17:12];
	assign bcd     = volt_to_bcd(volt);
	assign measure = adc_ready && (request_char_q == REQ_MEASURE);

	always_comb begin
		q_wdata        = '0;
		q_wdata.report = measure;
		q_wdata.err    = measure && ((volt == '0) || (volt >= VOLT_SAT));
		q_wdata.bcd    = bcd;
		if (bcd[19:16] != 4'd0)
			q_wdata.ndig = 3'd5;
		else if (bcd[15:12] != 4'd0)
			q_wdata.ndig = 3'd4;
		else if (bcd[11:8] != 4'd0)
			q_wdata.ndig = 3'd3;
		else if (bcd[7:4] != 4'd0)
			q_wdata.ndig = 3'd2;
		else
			q_wdata.ndig = 3'd1;
	end

	assign q_push = accept && cmd;

endmodule

// ----- rtl/core/adc_rar_queue.sv -----
// short job queue between front and back ends
`include "adc_resistance_ascii_reporter_unit_defines.svh"
module adc_rar_queue import adc_rar_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output job_t rdata,
	output logic empty
);

	job_t                entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ADC_RAR_ASSERT_NOW(a_q_bound, 1'b1, count_q <= Q_CNT_W'(Q_DEPTH), "queue count over depth")
	`ADC_RAR_ASSERT_NEXT(a_q_fill, push && !full && !pop, !empty, "queue empty after push")

endmodule

// ----- rtl/core/adc_rar_back.sv -----
// back end: walks a job one character per unstalled cycle into the output register
`include "adc_resistance_ascii_reporter_unit_defines.svh"
module adc_rar_back import adc_rar_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_rdata,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] text_char,
	output logic       last_char,
	output logic       range_error
);

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;

	state_t           state_q;
	job_t             job_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             err_q;
	logic             load_ok;
	logic [IDX_W-1:0] len;
	logic [NDIG_W-1:0] pos;
	logic [3:0]       nib;
	logic [7:0]       next_char;
	logic             next_last;

	assign load_ok = !out_valid_q || !out_stall;
	assign q_pop   = (state_q == ST_IDLE) && !q_empty;

	assign len = job_q.report ? {1'b0, job_q.ndig} + 4'd2 : MSG_LEN;
	assign pos = job_q.ndig - 3'd1 - idx_q[NDIG_W-1:0];

	always_comb begin
		case (pos)
			3'd0:    nib = job_q.bcd[3:0];
			3'd1:    nib = job_q.bcd[7:4];
			3'd2:    nib = job_q.bcd[11:8];
			3'd3:    nib = job_q.bcd[15:12];
			3'd4:    nib = job_q.bcd[19:16];
			default: nib = 4'd0;
		endcase
	end

	always_comb begin
		next_last = (idx_q == len - 4'd1);
		if (!job_q.report)
			next_char = msg_char(idx_q);
		else if (idx_q < {1'b0, job_q.ndig})
			next_char = CH_ZERO + {4'd0, nib};
		else if (idx_q == {1'b0, job_q.ndig})
			next_char = CH_CR;
		else
			next_char = CH_LF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						idx_q       <= idx_q + 1'b1;
						if (next_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_rdata;
		if (state_q == ST_EMIT && load_ok) begin
			char_q <= next_char;
			last_q <= next_last;
			err_q  <= job_q.err;
		end
	end

	assign out_valid   = out_valid_q;
	assign text_char   = char_q;
	assign last_char   = last_q;
	assign range_error = err_q;

	`ADC_RAR_ASSERT_NOW(a_last_lf, out_valid_q && last_q, char_q == CH_LF,
		"last character is not a line feed")
	`ADC_RAR_ASSERT_NOW(a_err_text, out_valid_q && err_q,
		char_q == CH_ZERO || char_q == CH_CR || char_q == CH_LF,
		"error report holds a character other than zero, cr, lf")

endmodule

// ----- rtl/core/adc_resistance_ascii_reporter_unit.sv -----
// top level of the adc resistance ascii reporter
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  config   | cfg_valid/cfg_ready | cfg_data (cal_offset)
//  input    | in_valid/in_stall   | cmd, rx_byte, adc_ready, adc_sample
//  output   | out_valid/out_stall | text_char, last_char, range_error
//
// a serial byte only updates the request character and gives no output
// a poll request becomes a job in the front end and is queued for the back end,
//   which sends digits + 2 characters for a report (3..7) or 11 for no action
// the back end emits one character per cycle when not stalled; a two-entry job
//   queue lets the front end keep taking requests while a line is still going out
// in_stall is high while the job queue is full; out_stall freezes the output register
// reset clears request character, offset, queue and back-end state
module adc_resistance_ascii_reporter_unit import adc_rar_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SAMPLE_W-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [7:0]          rx_byte,
	input  logic                adc_ready,
	input  logic [SAMPLE_W-1:0] adc_sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          text_char,
	output logic                last_char,
	output logic                range_error
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	job_t q_wdata;
	job_t q_rdata;

	adc_rar_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.rx_byte    (rx_byte),
		.adc_ready  (adc_ready),
		.adc_sample (adc_sample),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	adc_rar_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	adc_rar_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.text_char   (text_char),
		.last_char   (last_char),
		.range_error (range_error)
	);

endmodule
